// ----- rtl/sbwsu_pkg.sv -----
// Shared types, constants and helper functions for the split bf16 weight update block.
package sbwsu_pkg;

    localparam logic [30:0] INF_MAG   = 31'h7F800000;
    localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
    localparam logic [2:0]  ADDR_ALPHA = 3'd0;

    typedef logic signed [11:0] exp_t;

    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign_p;
        logic [31:0] m_p;
        exp_t        e_p;
        logic        sign_w;
        logic [23:0] m_w;
        exp_t        e_w;
        logic        w_zero;
    } prod_t;

    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic [62:0] m;
        exp_t        e;
    } sum_t;

    // position of the highest set bit; 0 for a zero word
    function automatic logic [5:0] msb63(input logic [62:0] v);
        logic [5:0] k;
        k = 6'd0;
        for (int i = 0; i < 63; i++)
        begin
            if (v[i])
            begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

    // right shift, any bit shifted out is or-ed into bit 0
    function automatic logic [61:0] shift_jam(input logic [61:0] v, input logic [5:0] d);
        logic [61:0] s;
        logic        lost;
        s = v >> d;
        lost = ((s << d) != v);
        return s | {61'd0, lost};
    endfunction

endpackage

// ----- rtl/sbwsu_mul.sv -----
// Stage one: operand decode, special-case resolution and the exact alpha*gradient product.
module sbwsu_mul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [31:0]          alpha,
    input  logic [15:0]          weight_top,
    input  logic [15:0]          weight_bottom,
    input  logic [15:0]          gradient,
    output logic                 valid_out,
    output sbwsu_pkg::prod_t     prod_out
);
    import sbwsu_pkg::*;

    logic        valid_reg;
    prod_t       prod_reg;
    prod_t       prod_next;
    logic [31:0] a;
    logic [31:0] g;
    logic [31:0] w;
    logic [30:0] aa;
    logic [30:0] ab;
    logic [30:0] ac;
    logic        sp;
    logic [23:0] ma;
    logic [7:0]  mg;
    exp_t        ea;
    exp_t        eg;

    always_comb
    begin
        a  = alpha;
        g  = {gradient, 16'd0};
        w  = {weight_top, weight_bottom};
        aa = a[30:0];
        ab = g[30:0];
        ac = w[30:0];
        sp = a[31] ^ g[31];

        ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
        ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
        mg = (gradient[14:7] == 8'd0) ? {1'b0, gradient[6:0]} : {1'b1, gradient[6:0]};
        eg = (gradient[14:7] == 8'd0) ? -12'sd133
                                      : $signed({4'd0, gradient[14:7]}) - 12'sd134;

        prod_next.special     = 1'b1;
        prod_next.special_val = QNAN_BITS;
        if (aa > INF_MAG || ab > INF_MAG || ac > INF_MAG)
        begin
            prod_next.special_val = QNAN_BITS;
        end
        else if (aa == INF_MAG || ab == INF_MAG)
        begin
            if (aa == 31'd0 || ab == 31'd0)
            begin
                prod_next.special_val = QNAN_BITS;
            end
            else if (ac == INF_MAG && w[31] != sp)
            begin
                prod_next.special_val = QNAN_BITS;
            end
            else
            begin
                prod_next.special_val = {sp, INF_MAG};
            end
        end
        else if (ac == INF_MAG)
        begin
            prod_next.special_val = w;
        end
        else if (aa == 31'd0 || ab == 31'd0)
        begin
            prod_next.special_val = (ac == 31'd0) ? {sp & w[31], 31'd0} : w;
        end
        else
        begin
            prod_next.special = 1'b0;
        end

        prod_next.sign_p = sp;
        prod_next.m_p    = {8'd0, ma} * {24'd0, mg};
        prod_next.e_p    = ea + eg;
        prod_next.sign_w = w[31];
        prod_next.m_w    = (w[30:23] == 8'd0) ? {1'b0, w[22:0]} : {1'b1, w[22:0]};
        prod_next.e_w    = (w[30:23] == 8'd0) ? -12'sd149
                                              : $signed({4'd0, w[30:23]}) - 12'sd150;
        prod_next.w_zero = (ac == 31'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign valid_out = valid_reg;
    assign prod_out  = prod_reg;

endmodule

// ----- rtl/sbwsu_align_add.sv -----
// Stage two: normalize product and weight, align with sticky, add or subtract.
module sbwsu_align_add
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  sbwsu_pkg::prod_t     prod_in,
    output logic                 valid_out,
    output sbwsu_pkg::sum_t      sum_out
);
    import sbwsu_pkg::*;

    logic        valid_reg;
    sum_t        sum_reg;
    sum_t        sum_next;
    logic [5:0]  sh_p;
    logic [5:0]  sh_w;
    logic [61:0] mpn;
    logic [61:0] mwn;
    exp_t        epn;
    exp_t        ewn;
    exp_t        diff;
    logic [5:0]  d;
    logic [61:0] mp;
    logic [61:0] mc;

    always_comb
    begin
        sh_p = 6'd61 - msb63({31'd0, prod_in.m_p});
        sh_w = 6'd61 - msb63({39'd0, prod_in.m_w});
        mpn  = {30'd0, prod_in.m_p} << sh_p;
        mwn  = {38'd0, prod_in.m_w} << sh_w;
        epn  = prod_in.e_p - $signed({6'd0, sh_p});
        ewn  = prod_in.e_w - $signed({6'd0, sh_w});
        diff = epn - ewn;
        d    = 6'd0;
        sum_next.e = epn;
        if (prod_in.w_zero)
        begin
            mp = mpn;
            mc = 62'd0;
        end
        else if (diff >= 12'sd0)
        begin
            d  = (diff > 12'sd63) ? 6'd63 : diff[5:0];
            mp = mpn;
            mc = shift_jam(mwn, d);
        end
        else
        begin
            d  = (diff < -12'sd63) ? 6'd63 : 6'(12'(-diff));
            mp = shift_jam(mpn, d);
            mc = mwn;
            sum_next.e = ewn;
        end

        if (prod_in.sign_p == prod_in.sign_w)
        begin
            sum_next.m    = {1'b0, mp} + {1'b0, mc};
            sum_next.sign = prod_in.sign_p;
        end
        else if (mp >= mc)
        begin
            sum_next.m    = {1'b0, mp - mc};
            sum_next.sign = prod_in.sign_p;
        end
        else
        begin
            sum_next.m    = {1'b0, mc - mp};
            sum_next.sign = prod_in.sign_w;
        end
        sum_next.special     = prod_in.special;
        sum_next.special_val = prod_in.special_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign valid_out = valid_reg;
    assign sum_out   = sum_reg;

endmodule

// ----- rtl/sbwsu_round.sv -----
// Stage three: round to binary32 nearest-even with subnormals, select special results.
module sbwsu_round
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  sbwsu_pkg::sum_t      sum_in,
    output logic                 valid_out,
    output logic [31:0]          result
);
    import sbwsu_pkg::*;

    logic        valid_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    exp_t        k;
    exp_t        r;
    exp_t        lim;
    exp_t        ex;
    exp_t        biased;
    logic [5:0]  rsh;
    logic [4:0]  lsh;
    logic [62:0] hi;
    logic [24:0] q;
    logic        guard;
    logic        sticky;

    always_comb
    begin
        k   = $signed({6'd0, msb63(sum_in.m)});
        r   = k - 12'sd23;
        lim = -12'sd149 - sum_in.e;
        if (lim > r)
        begin
            r = lim;
        end
        rsh    = 6'd0;
        lsh    = 5'd0;
        hi     = 63'd0;
        guard  = 1'b0;
        sticky = 1'b0;
        q      = 25'd0;
        if (r <= 12'sd0)
        begin
            lsh = 5'(12'(-r));
            q   = 25'(sum_in.m << lsh);
        end
        else if (r <= 12'sd63)
        begin
            rsh    = r[5:0];
            q      = 25'(sum_in.m >> rsh);
            hi     = sum_in.m >> (rsh - 6'd1);
            guard  = hi[0];
            sticky = ((hi << (rsh - 6'd1)) != sum_in.m);
            q      = q + {24'd0, guard & (sticky | q[0])};
        end
        ex = r + sum_in.e;
        if (q[24])
        begin
            q  = q >> 1;
            ex = ex + 12'sd1;
        end
        biased = ex + 12'sd150;

        if (sum_in.special)
        begin
            result_next = sum_in.special_val;
        end
        else if (sum_in.m == 63'd0)
        begin
            result_next = 32'd0;
        end
        else if (r > 12'sd63)
        begin
            result_next = {sum_in.sign, 31'd0};
        end
        else if (!q[23])
        begin
            result_next = {sum_in.sign, 8'd0, q[22:0]};
        end
        else if (biased >= 12'sd255)
        begin
            result_next = {sum_in.sign, INF_MAG};
        end
        else
        begin
            result_next = {sum_in.sign, biased[7:0], q[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign valid_out = valid_reg;
    assign result    = result_reg;

endmodule

// ----- rtl/split_bf16_weight_sgd_update.sv -----
// Split bf16 weight update: new weight = weight + alpha * gradient, one rounding.
// Takes one request per cycle while s_tready is high; each passes the input register,
// then the product, align/add and round stages. A full stage holds while the stage
// ahead holds, so a held result stalls the full stages behind it. Alpha is a binary32
// pattern written at APB address 0; NaN results are 0x7FC00000, subnormals are kept.
module split_bf16_weight_sgd_update
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // weight_top, weight_bottom, gradient
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // new_weight_top, new_weight_bottom
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbwsu_pkg::*;

    logic [31:0] alpha_reg;
    logic        in_valid_reg;
    logic [47:0] in_data_reg;
    logic        en_in;
    logic        en_mul;
    logic        en_add;
    logic        en_rnd;
    logic        mul_valid;
    logic        add_valid;
    logic        rnd_valid;
    prod_t       prod;
    sum_t        sum;
    logic [31:0] result;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ALPHA) ? alpha_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_ALPHA)
        begin
            alpha_reg <= pwdata;
        end
    end

    assign en_rnd   = !rnd_valid || m_tready;
    assign en_add   = !add_valid || en_rnd;
    assign en_mul   = !mul_valid || en_add;
    assign en_in    = !in_valid_reg || en_mul;
    assign s_tready = en_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en_in)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    sbwsu_mul u_mul
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en_mul),
        .valid_in      (in_valid_reg),
        .alpha         (alpha_reg),
        .weight_top    (in_data_reg[15:0]),
        .weight_bottom (in_data_reg[31:16]),
        .gradient      (in_data_reg[47:32]),
        .valid_out     (mul_valid),
        .prod_out      (prod)
    );

    sbwsu_align_add u_add
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_add),
        .valid_in  (mul_valid),
        .prod_in   (prod),
        .valid_out (add_valid),
        .sum_out   (sum)
    );

    sbwsu_round u_rnd
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_rnd),
        .valid_in  (add_valid),
        .sum_in    (sum),
        .valid_out (rnd_valid),
        .result    (result)
    );

    assign m_tvalid = rnd_valid;
    assign m_tdata  = {result[15:0], result[31:16]};

endmodule

// ----- rtl/sbwsu_checker.sv -----
// Port-level checks for the split bf16 weight update block, bound to the top level.
module sbwsu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import sbwsu_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    a_alpha_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == ADDR_ALPHA |=>
            paddr != ADDR_ALPHA || prdata == $past(pwdata))
        else $error("alpha readback mismatch");

    a_nan_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14:7] == 8'hFF && (m_tdata[6:0] != 7'd0 || m_tdata[31:16] != 16'd0)
            |-> m_tdata[15:0] == 16'h7FC0 && m_tdata[31:16] == 16'd0)
        else $error("non-canonical NaN result");

endmodule

bind split_bf16_weight_sgd_update sbwsu_checker u_sbwsu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
